// ----- src/assert_macros.svh -----
// Assertion helpers for the RTL file that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SCCC_ASSERT_IMP(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// Next-cycle implication.
`define SCCC_ASSERT_NXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

// ----- src/sccc_pkg.sv -----
package sccc_pkg;

   localparam int COORD_BITS         = 16;
   localparam int MAX_WINDOW_DEFAULT = 8;
   localparam int KREG_BITS          = 4;
   localparam int KREG_RESET         = 3;
   localparam int COS_BITS           = 29;
   localparam int FRAC_SHIFT         = 32;

   // cos^2(75 deg) in Q0.32.
   localparam logic [COS_BITS-1:0] COS2_75_Q32 = 29'd287708255;

   // Squared distances in Q8.8 squared units.
   localparam int D2_0P5     = 16384;
   localparam int D2_1P5     = 147456;
   localparam int D2_2P0     = 262144;
   localparam int D2_2P5     = 409600;
   localparam int D2_0P8_X25 = 1048576;

   typedef enum logic [1:0] {
      CLASS_NONE,
      CLASS_PEDESTRIAN,
      CLASS_FRONT,
      CLASS_CORNER
   } class_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
   } point_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
      logic                         last_point;
   } req_type;

   typedef struct packed {
      class_type                    obstacle_class;
      logic [2:0]                   interest_count;
      logic signed [COORD_BITS-1:0] first_x;
      logic signed [COORD_BITS-1:0] first_y;
      logic signed [COORD_BITS-1:0] second_x;
      logic signed [COORD_BITS-1:0] second_y;
      logic signed [COORD_BITS-1:0] third_x;
      logic signed [COORD_BITS-1:0] third_y;
      logic signed [COORD_BITS-1:0] pedestrian_x;
      logic signed [COORD_BITS-1:0] pedestrian_y;
   } rsp_type;

   typedef enum logic [2:0] {
      T_IDLE,
      T_SUM,
      T_UV,
      T_AGO,
      T_AWAIT,
      T_FINAL,
      T_CPREP,
      T_OUT
   } top_state_type;

   typedef enum logic [1:0] {
      AS_IDLE,
      AS_ISSUE,
      AS_WAIT,
      AS_DONE
   } ang_state_type;

   typedef enum logic [3:0] {
      OP_UXX,
      OP_UYY,
      OP_VXX,
      OP_VYY,
      OP_XDOT,
      OP_YDOT,
      OP_DSQ,
      OP_CMU,
      OP_CMV
   } op_type;

   typedef struct packed {
      logic idle;
      logic done;
      logic pass;
   } ang_stat_type;

endpackage

// ----- src/scan_cluster_corner_classifier_unit.sv -----
// A point that is not tested for an angle passes through T_FINAL before the next ready.
// A tested middle point sums its window in T_SUM and forms its vectors in T_UV, then runs
// one angle test of 9 bit-serial products on the shared multiplier, which sets its pace.
// With two or three interest points, the last point adds an angle test for the class, then
// the result register loads. Reset (synchronous) clears the sequencer, point and interest
// counts, and sets k to 3; window and interest point storage stays undefined until written.
`include "assert_macros.svh"

module scan_cluster_corner_classifier_unit #(
   parameter int MAX_WINDOW = sccc_pkg::MAX_WINDOW_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  sccc_pkg::req_type               req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output sccc_pkg::rsp_type               rsp_payload,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sccc_pkg::KREG_BITS-1:0]  csr_data
);
   import sccc_pkg::*;

   localparam int DEPTH = 2 * MAX_WINDOW + 1;
   localparam int IW    = $clog2(DEPTH);
   localparam int KW    = $clog2(MAX_WINDOW + 1);
   localparam int CW    = COORD_BITS;
   localparam int VW    = CW + KW + 1;
   localparam int QW    = 2 * VW + 1;

   top_state_type state_ff, state_in;

   point_type window_ff [DEPTH];
   point_type window_in [DEPTH];
   point_type ipt_ff [3];
   point_type ipt_in [3];
   point_type c_ff, c_in, rd, rec_pt;

   logic [IW-1:0]          seen_ff, seen_in, t_ff, t_in, twok;
   logic [2:0]             itot_ff, itot_in;
   logic [KREG_BITS-1:0]   k_ff;
   logic [KW-1:0]          kc;
   logic                   last_ff, last_in, phase_ff, phase_in, rec_en;
   logic signed [VW-1:0]   sax_ff, sax_in, say_ff, say_in, sbx_ff, sbx_in, sby_ff, sby_in;
   logic signed [VW-1:0]   ux_ff, ux_in, uy_ff, uy_in, vx_ff, vx_in, vy_ff, vy_in;
   logic signed [VW-1:0]   kcx, kcy;
   class_type              cls_ff, cls_in, cls_calc;
   point_type              ped_ff, ped_in, ped_calc;
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   accept, out_go;

   ang_stat_type           ang_stat;
   logic [QW-1:0]          ang_mu, ang_mv, d_lo, d_hi;
   logic [CW:0]            adx, ady;
   logic signed [CW:0]     dx, dy, sumx, sumy;
   logic [CW+3:0]          ady5, adx3;
   logic [QW+4:0]          d25;
   logic                   corner_ok;

   sccc_angle #(.VW(VW)) u_angle (
      .clock   (clock),
      .reset   (reset),
      .start_i (state_ff == T_AGO),
      .ux_i    (ux_ff),
      .uy_i    (uy_ff),
      .vx_i    (vx_ff),
      .vy_i    (vy_ff),
      .stat_o  (ang_stat),
      .mu_o    (ang_mu),
      .mv_o    (ang_mv)
   );

   always_comb begin
      if (k_ff == '0) begin
         kc = KW'(1);
      end else if (int'(k_ff) > MAX_WINDOW) begin
         kc = KW'(MAX_WINDOW);
      end else begin
         kc = KW'(k_ff);
      end
   end

   // A register write never shares an edge with a point transfer, so one point sees one k.
   assign twok      = IW'({kc, 1'b0});
   assign accept    = req_valid && !req_stall;
   assign out_go    = (state_ff == T_OUT) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = (state_ff != T_IDLE);
   assign csr_ready = (state_ff == T_IDLE) && !req_valid;
   assign rd        = window_ff[t_ff];
   assign kcx       = VW'(signed'({1'b0, kc})) * VW'(c_ff.x);
   assign kcy       = VW'(signed'({1'b0, kc})) * VW'(c_ff.y);

   // Classification terms from the first interest points and the angle unit results.
   always_comb begin
      d_lo      = (ang_mu < ang_mv) ? ang_mu : ang_mv;
      d_hi      = (ang_mu < ang_mv) ? ang_mv : ang_mu;
      corner_ok = ang_stat.pass &&
                  d_hi > QW'(D2_1P5) && d_hi < QW'(D2_2P5) &&
                  d_lo > QW'(D2_0P5) && d_lo < QW'(D2_1P5);
      dx   = (CW+1)'(ipt_ff[1].x) - (CW+1)'(ipt_ff[0].x);
      dy   = (CW+1)'(ipt_ff[1].y) - (CW+1)'(ipt_ff[0].y);
      adx  = dx[CW] ? (CW+1)'(-dx) : (CW+1)'(dx);
      ady  = dy[CW] ? (CW+1)'(-dy) : (CW+1)'(dy);
      ady5 = (CW+4)'(ady) * (CW+4)'(5);
      adx3 = (CW+4)'(adx) * (CW+4)'(3);
      d25  = (QW+5)'(ang_mu) * (QW+5)'(25);
      sumx = (CW+1)'(ipt_ff[0].x) + (CW+1)'(ipt_ff[1].x);
      sumy = (CW+1)'(ipt_ff[0].y) + (CW+1)'(ipt_ff[1].y);
      cls_calc   = CLASS_NONE;
      ped_calc.x = '0;
      ped_calc.y = '0;
      if (itot_ff == 3'd3) begin
         if (corner_ok) cls_calc = CLASS_CORNER;
      end else if (itot_ff == 3'd2 && ady5 < adx3) begin
         if (d25 > (QW+5)'(D2_0P8_X25) && ang_mu < QW'(D2_2P0)) begin
            cls_calc = CLASS_FRONT;
         end else if (d25 < (QW+5)'(D2_0P8_X25)) begin
            cls_calc   = CLASS_PEDESTRIAN;
            ped_calc.x = sumx[CW:1];
            ped_calc.y = sumy[CW:1];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         T_IDLE: begin
            if (accept) begin
               state_in = (seen_ff != '0 && seen_ff >= twok) ? T_SUM : T_FINAL;
            end
         end
         T_SUM:   if (t_ff == twok) state_in = T_UV;
         T_UV:    state_in = T_AGO;
         T_AGO:   state_in = T_AWAIT;
         T_AWAIT: if (ang_stat.done) state_in = phase_ff ? T_OUT : T_FINAL;
         T_FINAL: state_in = last_ff ? T_CPREP : T_IDLE;
         T_CPREP: state_in = (itot_ff == 3'd2 || itot_ff == 3'd3) ? T_AGO : T_OUT;
         T_OUT:   if (out_go) state_in = T_IDLE;
         default: state_in = T_IDLE;
      endcase
   end

   always_comb begin
      window_in    = window_ff;
      ipt_in       = ipt_ff;
      seen_in      = seen_ff;
      itot_in      = itot_ff;
      t_in         = t_ff;
      last_in      = last_ff;
      phase_in     = phase_ff;
      c_in         = c_ff;
      sax_in       = sax_ff;
      say_in       = say_ff;
      sbx_in       = sbx_ff;
      sby_in       = sby_ff;
      ux_in        = ux_ff;
      uy_in        = uy_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      cls_in       = cls_ff;
      ped_in       = ped_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rec_en       = 1'b0;
      rec_pt       = window_ff[0];

      case (state_ff)
         T_IDLE: begin
            if (accept) begin
               for (int i = DEPTH - 1; i > 0; i--) begin
                  window_in[i] = window_ff[i-1];
               end
               window_in[0].x = req_payload.point_x;
               window_in[0].y = req_payload.point_y;
               if (seen_ff < IW'(2 * MAX_WINDOW)) seen_in = seen_ff + IW'(1);
               last_in  = req_payload.last_point;
               phase_in = 1'b0;
               t_in     = '0;
               sax_in   = '0;
               say_in   = '0;
               sbx_in   = '0;
               sby_in   = '0;
               if (seen_ff == '0) begin
                  rec_en   = 1'b1;
                  rec_pt.x = req_payload.point_x;
                  rec_pt.y = req_payload.point_y;
               end
            end
         end
         T_SUM: begin
            // Newer points sit below the center tap, older ones above it.
            if (t_ff < IW'(kc)) begin
               sbx_in = sbx_ff + VW'(rd.x);
               sby_in = sby_ff + VW'(rd.y);
            end else if (t_ff == IW'(kc)) begin
               c_in = rd;
            end else begin
               sax_in = sax_ff + VW'(rd.x);
               say_in = say_ff + VW'(rd.y);
            end
            t_in = t_ff + IW'(1);
         end
         T_UV: begin
            ux_in = kcx - sax_ff;
            uy_in = kcy - say_ff;
            vx_in = kcx - sbx_ff;
            vy_in = kcy - sby_ff;
         end
         T_AWAIT: begin
            if (ang_stat.done) begin
               if (phase_ff) begin
                  cls_in = cls_calc;
                  ped_in = ped_calc;
               end else if (ang_stat.pass) begin
                  rec_en = 1'b1;
                  rec_pt = c_ff;
               end
            end
         end
         T_FINAL: begin
            if (last_ff) rec_en = 1'b1;
         end
         T_CPREP: begin
            phase_in = 1'b1;
            cls_in   = CLASS_NONE;
            ped_in.x = '0;
            ped_in.y = '0;
            ux_in    = VW'(ipt_ff[1].x) - VW'(ipt_ff[0].x);
            uy_in    = VW'(ipt_ff[1].y) - VW'(ipt_ff[0].y);
            if (itot_ff == 3'd3) begin
               vx_in = VW'(ipt_ff[1].x) - VW'(ipt_ff[2].x);
               vy_in = VW'(ipt_ff[1].y) - VW'(ipt_ff[2].y);
            end else begin
               vx_in = VW'(ipt_ff[1].x) - VW'(ipt_ff[0].x);
               vy_in = VW'(ipt_ff[1].y) - VW'(ipt_ff[0].y);
            end
         end
         T_OUT: begin
            if (out_go) begin
               rsp_in.obstacle_class = cls_ff;
               rsp_in.interest_count = itot_ff;
               rsp_in.first_x        = (itot_ff >= 3'd1) ? ipt_ff[0].x : '0;
               rsp_in.first_y        = (itot_ff >= 3'd1) ? ipt_ff[0].y : '0;
               rsp_in.second_x       = (itot_ff >= 3'd2) ? ipt_ff[1].x : '0;
               rsp_in.second_y       = (itot_ff >= 3'd2) ? ipt_ff[1].y : '0;
               rsp_in.third_x        = (itot_ff >= 3'd3) ? ipt_ff[2].x : '0;
               rsp_in.third_y        = (itot_ff >= 3'd3) ? ipt_ff[2].y : '0;
               rsp_in.pedestrian_x   = ped_ff.x;
               rsp_in.pedestrian_y   = ped_ff.y;
               rsp_valid_in          = 1'b1;
               seen_in               = '0;
               itot_in               = '0;
            end
         end
         default: begin
            rec_en = 1'b0;
         end
      endcase

      if (rec_en) begin
         if (itot_ff < 3'd3) ipt_in[itot_ff[1:0]] = rec_pt;
         if (itot_ff < 3'd4) itot_in = itot_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         seen_ff      <= '0;
         itot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         k_ff         <= KREG_BITS'(KREG_RESET);
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         itot_ff      <= itot_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) k_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
      ipt_ff    <= ipt_in;
      t_ff      <= t_in;
      last_ff   <= last_in;
      phase_ff  <= phase_in;
      c_ff      <= c_in;
      sax_ff    <= sax_in;
      say_ff    <= say_in;
      sbx_ff    <= sbx_in;
      sby_ff    <= sby_in;
      ux_ff     <= ux_in;
      uy_ff     <= uy_in;
      vx_ff     <= vx_in;
      vy_ff     <= vy_in;
      cls_ff    <= cls_in;
      ped_ff    <= ped_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `SCCC_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `SCCC_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, itot_ff <= 3'd4)
   `SCCC_ASSERT_IMP(a_angle_free_on_start, clock, reset, state_ff == T_AGO, ang_stat.idle)
   `SCCC_ASSERT_IMP(a_rsp_from_out, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == T_OUT)

endmodule

// ----- src/sccc_mul.sv -----
module sccc_mul #(
   parameter int AW = 75,
   parameter int BW = 43
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start_i,
   input  logic [AW-1:0]    a_i,
   input  logic [BW-1:0]    b_i,
   output logic             done_o,
   output logic [AW+BW-1:0] prod_o
);
   localparam int PW   = AW + BW;
   localparam int CNTW = $clog2(BW + 1);

   logic [PW-1:0]   acc_ff, acc_in;
   logic [PW-1:0]   ash_ff, ash_in;
   logic [BW-1:0]   bsh_ff, bsh_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            run_ff, run_in;

   // One multiplier bit per cycle, least significant first.
   always_comb begin
      acc_in = acc_ff;
      ash_in = ash_ff;
      bsh_in = bsh_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      if (start_i) begin
         acc_in = '0;
         ash_in = PW'(a_i);
         bsh_in = b_i;
         cnt_in = CNTW'(BW);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (cnt_ff != '0) begin
            acc_in = bsh_ff[0] ? acc_ff + ash_ff : acc_ff;
            ash_in = ash_ff << 1;
            bsh_in = bsh_ff >> 1;
            cnt_in = cnt_ff - CNTW'(1);
         end else begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      ash_ff <= ash_in;
      bsh_ff <= bsh_in;
   end

   assign done_o = run_ff && (cnt_ff == '0);
   assign prod_o = acc_ff;

endmodule

// ----- src/sccc_angle.sv -----
module sccc_angle #(
   parameter int VW = 21
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start_i,
   input  logic signed [VW-1:0]      ux_i,
   input  logic signed [VW-1:0]      uy_i,
   input  logic signed [VW-1:0]      vx_i,
   input  logic signed [VW-1:0]      vy_i,
   output sccc_pkg::ang_stat_type    stat_o,
   output logic [2*VW:0]             mu_o,
   output logic [2*VW:0]             mv_o
);
   import sccc_pkg::*;

   localparam int QW = 2 * VW + 1;
   localparam int AW = QW + FRAC_SHIFT;
   localparam int BW = QW;
   localparam int PW = AW + BW;

   ang_state_type state_ff, state_in;
   op_type        op_ff, op_in;

   logic [VW-1:0]        mux_ff, muy_ff, mvx_ff, mvy_ff;
   logic                 sx_ff, sy_ff;
   logic [QW-1:0]        mu_ff, mu_in, mv_ff, mv_in;
   logic signed [QW:0]   dot_ff, dot_in;
   logic [2*QW-1:0]      sq_ff, sq_in;
   logic [PW-1:0]        r_ff, r_in;

   logic                 mul_start, mul_done;
   logic [AW-1:0]        mul_a;
   logic [BW-1:0]        mul_b;
   logic [PW-1:0]        mul_prod;
   logic [QW-1:0]        adot;
   logic signed [QW:0]   term;

   function automatic logic [VW-1:0] mag_of(input logic signed [VW-1:0] v);
      return v[VW-1] ? VW'(-v) : VW'(v);
   endfunction

   sccc_mul #(.AW(AW), .BW(BW)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start_i (mul_start),
      .a_i     (mul_a),
      .b_i     (mul_b),
      .done_o  (mul_done),
      .prod_o  (mul_prod)
   );

   assign adot = dot_ff[QW] ? QW'(-dot_ff) : QW'(dot_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         AS_IDLE:  if (start_i) state_in = AS_ISSUE;
         AS_ISSUE: state_in = AS_WAIT;
         AS_WAIT: begin
            if (mul_done) state_in = (op_ff == OP_CMV) ? AS_DONE : AS_ISSUE;
         end
         AS_DONE:  state_in = AS_IDLE;
         default:  state_in = AS_IDLE;
      endcase
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (op_ff)
         OP_UXX:  begin mul_a = AW'(mux_ff); mul_b = BW'(mux_ff); end
         OP_UYY:  begin mul_a = AW'(muy_ff); mul_b = BW'(muy_ff); end
         OP_VXX:  begin mul_a = AW'(mvx_ff); mul_b = BW'(mvx_ff); end
         OP_VYY:  begin mul_a = AW'(mvy_ff); mul_b = BW'(mvy_ff); end
         OP_XDOT: begin mul_a = AW'(mux_ff); mul_b = BW'(mvx_ff); end
         OP_YDOT: begin mul_a = AW'(muy_ff); mul_b = BW'(mvy_ff); end
         OP_DSQ:  begin mul_a = AW'(adot);   mul_b = adot;        end
         OP_CMU:  begin mul_a = AW'(COS2_75_Q32); mul_b = mu_ff;  end
         OP_CMV:  begin mul_a = r_ff[AW-1:0]; mul_b = mv_ff;      end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_comb begin
      mul_start = (state_ff == AS_ISSUE);
      op_in     = op_ff;
      mu_in     = mu_ff;
      mv_in     = mv_ff;
      dot_in    = dot_ff;
      sq_in     = sq_ff;
      r_in      = r_ff;
      term      = signed'({1'b0, mul_prod[QW-1:0]});
      if (state_ff == AS_IDLE && start_i) begin
         op_in = OP_UXX;
      end else if (state_ff == AS_WAIT && mul_done) begin
         if (op_ff != OP_CMV) op_in = op_type'(op_ff + 4'd1);
         case (op_ff)
            OP_UXX:  mu_in  = mul_prod[QW-1:0];
            OP_UYY:  mu_in  = mu_ff + mul_prod[QW-1:0];
            OP_VXX:  mv_in  = mul_prod[QW-1:0];
            OP_VYY:  mv_in  = mv_ff + mul_prod[QW-1:0];
            OP_XDOT: dot_in = sx_ff ? -term : term;
            OP_YDOT: dot_in = sy_ff ? dot_ff - term : dot_ff + term;
            OP_DSQ:  sq_in  = mul_prod[2*QW-1:0];
            OP_CMU:  r_in   = mul_prod;
            OP_CMV:  r_in   = mul_prod;
            default: r_in   = r_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= AS_IDLE;
         op_ff    <= OP_UXX;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == AS_IDLE && start_i) begin
         mux_ff <= mag_of(ux_i);
         muy_ff <= mag_of(uy_i);
         mvx_ff <= mag_of(vx_i);
         mvy_ff <= mag_of(vy_i);
         sx_ff  <= ux_i[VW-1] ^ vx_i[VW-1];
         sy_ff  <= uy_i[VW-1] ^ vy_i[VW-1];
      end
      mu_ff  <= mu_in;
      mv_ff  <= mv_in;
      dot_ff <= dot_in;
      sq_ff  <= sq_in;
      r_ff   <= r_in;
   end

   // The angle passes when dot^2 * 2^32 < C * |u|^2 * |v|^2 with both vectors nonzero.
   assign stat_o.idle = (state_ff == AS_IDLE);
   assign stat_o.done = (state_ff == AS_DONE);
   assign stat_o.pass = (mu_ff != '0) && (mv_ff != '0) &&
                        ({sq_ff, {FRAC_SHIFT{1'b0}}} < r_ff);
   assign mu_o = mu_ff;
   assign mv_o = mv_ff;

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import sccc_pkg::*;

   localparam int  WIN_DEPTH   = 2 * MAX_WINDOW_DEFAULT + 1;
   localparam int  SEEN_MAX    = 2 * MAX_WINDOW_DEFAULT;
   localparam int  DRAIN_WAIT  = 1500;
   localparam longint CYCLE_LIMIT = 20000000;
   localparam int  ITEMS_PER_PHASE = 135;

   typedef enum int {SHAPE_CORNER, SHAPE_FRONT, SHAPE_PEDESTRIAN, SHAPE_NOISE} shape_kind_type;

   typedef struct {
      req_type pt;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_type              req_payload;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_type              rsp_payload;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [KREG_BITS-1:0] csr_data;

   scan_cluster_corner_classifier_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // Predictor state.
   logic [KREG_BITS-1:0] window_reg;
   longint               hist_x[WIN_DEPTH];
   longint               hist_y[WIN_DEPTH];
   int                   seen_count;
   longint               corner_x[3];
   longint               corner_y[3];
   int                   corner_total;

   rsp_type              class_queue[$];
   int                   error_count;
   longint               cycle_count;
   int                   send_idle_pct;
   int                   stall_pct;
   int                   items_sent;
   req_type              shape_pts[$];

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Dot product test against cos^2(75 deg), on wide unsigned values.
   function automatic bit near_right(longint ux, longint uy, longint vx, longint vy);
      logic [191:0] mu, mv, ad, lhs, rhs;
      longint       d;
      mu = ux * ux + uy * uy;
      mv = vx * vx + vy * vy;
      d  = ux * vx + uy * vy;
      ad = (d < 0) ? -d : d;
      if (mu == 0 || mv == 0) return 1'b0;
      lhs = (ad * ad) << FRAC_SHIFT;
      rhs = 192'(COS2_75_Q32) * mu * mv;
      return lhs < rhs;
   endfunction

   function automatic void add_interest(longint x, longint y);
      if (corner_total < 3) begin
         corner_x[corner_total] = x;
         corner_y[corner_total] = y;
      end
      if (corner_total < 4) corner_total++;
   endfunction

   function automatic longint gap_sq(int a, int b);
      longint dx, dy;
      dx = corner_x[a] - corner_x[b];
      dy = corner_y[a] - corner_y[b];
      return dx * dx + dy * dy;
   endfunction

   function automatic void predictor_reset();
      window_reg   = KREG_BITS'(KREG_RESET);
      seen_count   = 0;
      corner_total = 0;
      for (int i = 0; i < WIN_DEPTH; i++) begin
         hist_x[i] = 0;
         hist_y[i] = 0;
      end
   endfunction

   // Advances the predictor by one point; returns 1 with the class when the cluster ends.
   function automatic bit classify_point(req_type pt, output rsp_type res);
      longint    x, y, cx, cy, ax, ay, bx, by, a, b, lo, hi, adx, ady, d2, mx, my;
      int        k, n;
      class_type cls;
      x  = pt.point_x;
      y  = pt.point_y;
      k  = window_reg;
      mx = 0;
      my = 0;
      cls = CLASS_NONE;
      res = '0;
      if (k < 1) k = 1;
      if (k > MAX_WINDOW_DEFAULT) k = MAX_WINDOW_DEFAULT;
      for (int i = WIN_DEPTH - 1; i > 0; i--) begin
         hist_x[i] = hist_x[i-1];
         hist_y[i] = hist_y[i-1];
      end
      hist_x[0] = x;
      hist_y[0] = y;
      if (seen_count == 0) begin
         add_interest(x, y);
      end else if (seen_count >= 2 * k) begin
         cx = hist_x[k];
         cy = hist_y[k];
         ax = 0; ay = 0; bx = 0; by = 0;
         for (int j = 1; j <= k; j++) begin
            ax += hist_x[k+j];
            ay += hist_y[k+j];
            bx += hist_x[k-j];
            by += hist_y[k-j];
         end
         if (near_right(k * cx - ax, k * cy - ay, k * cx - bx, k * cy - by))
            add_interest(cx, cy);
      end
      if (seen_count < SEEN_MAX) seen_count++;
      if (!pt.last_point) return 1'b0;

      add_interest(x, y);
      if (corner_total == 3) begin
         a  = gap_sq(0, 1);
         b  = gap_sq(1, 2);
         lo = (a < b) ? a : b;
         hi = (a < b) ? b : a;
         if (near_right(corner_x[1] - corner_x[0], corner_y[1] - corner_y[0],
                        corner_x[1] - corner_x[2], corner_y[1] - corner_y[2]) &&
             hi > D2_1P5 && hi < D2_2P5 && lo > D2_0P5 && lo < D2_1P5)
            cls = CLASS_CORNER;
      end else if (corner_total == 2) begin
         adx = corner_x[1] - corner_x[0];
         ady = corner_y[1] - corner_y[0];
         if (adx < 0) adx = -adx;
         if (ady < 0) ady = -ady;
         d2 = gap_sq(0, 1);
         if (5 * ady < 3 * adx) begin
            if (25 * d2 > D2_0P8_X25 && d2 < D2_2P0) begin
               cls = CLASS_FRONT;
            end else if (25 * d2 < D2_0P8_X25) begin
               cls = CLASS_PEDESTRIAN;
               // Arithmetic shift gives the midpoint rounded toward minus infinity.
               mx = (corner_x[0] + corner_x[1]) >>> 1;
               my = (corner_y[0] + corner_y[1]) >>> 1;
            end
         end
      end
      n = (corner_total < 3) ? corner_total : 3;
      res.obstacle_class = cls;
      res.interest_count = 3'(corner_total);
      if (n > 0) begin res.first_x  = 16'(corner_x[0]); res.first_y  = 16'(corner_y[0]); end
      if (n > 1) begin res.second_x = 16'(corner_x[1]); res.second_y = 16'(corner_y[1]); end
      if (n > 2) begin res.third_x  = 16'(corner_x[2]); res.third_y  = 16'(corner_y[2]); end
      res.pedestrian_x = 16'(mx);
      res.pedestrian_y = 16'(my);
      seen_count   = 0;
      corner_total = 0;
      return 1'b1;
   endfunction

   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // Result side: compare each transfer, then pick the next stall.
   always @(posedge clock) begin
      rsp_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (class_queue.size() == 0) begin
            $error("result transfer with nothing expected");
            error_count++;
         end else begin
            w = class_queue.pop_front();
            check_field("obstacle_class", w.obstacle_class, rsp_payload.obstacle_class);
            check_field("interest_count", w.interest_count, rsp_payload.interest_count);
            check_field("first_x", w.first_x, rsp_payload.first_x);
            check_field("first_y", w.first_y, rsp_payload.first_y);
            check_field("second_x", w.second_x, rsp_payload.second_x);
            check_field("second_y", w.second_y, rsp_payload.second_y);
            check_field("third_x", w.third_x, rsp_payload.third_x);
            check_field("third_y", w.third_y, rsp_payload.third_y);
            check_field("pedestrian_x", w.pedestrian_x, rsp_payload.pedestrian_x);
            check_field("pedestrian_y", w.pedestrian_y, rsp_payload.pedestrian_y);
         end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic send_point(req_type pt, bit typed, rsp_type want);
      rsp_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= pt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (classify_point(pt, res)) class_queue.insert(class_queue.size(), typed ? want : res);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (class_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_window(logic [KREG_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid  <= 1'b0;
      window_reg = value;
   endtask

   function automatic req_type make_point(longint x, longint y, bit last);
      req_type p;
      p.point_x    = 16'(x);
      p.point_y    = 16'(y);
      p.last_point = last;
      return p;
   endfunction

   // Builds one cluster; most are shaped like real objects with random placement.
   function automatic void build_cluster(shape_kind_type kind);
      real    th, ca, sa, la, lb, jit;
      longint ox, oy;
      int     na, nb, n, flip;
      shape_pts.delete();
      ox = $urandom_range(50000) - 25000;
      oy = $urandom_range(50000) - 25000;
      th = $urandom_range(359) * 3.14159265 / 180.0;
      ca = $cos(th);
      sa = $sin(th);
      case (kind)
         SHAPE_CORNER: begin
            la   = $urandom_range(390, 640);
            lb   = $urandom_range(130, 380);
            na   = $urandom_range(2, 9);
            nb   = $urandom_range(2, 9);
            flip = $urandom_range(1);
            jit  = ($urandom_range(20) - 10.0) * 3.14159265 / 180.0;
            for (int i = 0; i <= na; i++)
               shape_pts.insert(shape_pts.size(), make_point(
                  ox + longint'(ca * la * (na - i) / na) + $urandom_range(4),
                  oy + longint'(sa * la * (na - i) / na) + $urandom_range(4), 1'b0));
            for (int i = 1; i <= nb; i++)
               shape_pts.insert(shape_pts.size(), make_point(
                  ox - longint'($sin(th + jit) * lb * i / nb) + $urandom_range(4),
                  oy + longint'($cos(th + jit) * lb * i / nb) + $urandom_range(4), 1'b0));
            if (flip) shape_pts.reverse();
         end
         SHAPE_FRONT, SHAPE_PEDESTRIAN: begin
            la = (kind == SHAPE_FRONT) ? $urandom_range(200, 520) : $urandom_range(0, 230);
            n  = $urandom_range(1, (kind == SHAPE_FRONT) ? 10 : 4);
            th = ($urandom_range(60) - 30.0) * 3.14159265 / 180.0;
            for (int i = 0; i <= n; i++)
               shape_pts.insert(shape_pts.size(),
                  make_point(ox + longint'($cos(th) * la * i / n),
                             oy + longint'($sin(th) * la * i / n) + $urandom_range(3), 1'b0));
         end
         default: begin
            n = $urandom_range(1, 14);
            for (int i = 0; i < n; i++)
               shape_pts.insert(shape_pts.size(),
                  make_point($urandom_range(65535) - 32768,
                             $urandom_range(65535) - 32768, 1'b0));
         end
      endcase
      shape_pts[shape_pts.size() - 1].last_point = 1'b1;
   endfunction

   function automatic rsp_type two_point(class_type cls, longint x0, longint y0,
                                         longint x1, longint y1, longint mx, longint my);
      rsp_type r;
      r = '0;
      r.obstacle_class = cls;
      r.interest_count = 3'd2;
      r.first_x  = 16'(x0);
      r.first_y  = 16'(y0);
      r.second_x = 16'(x1);
      r.second_y = 16'(y1);
      r.pedestrian_x = 16'(mx);
      r.pedestrian_y = 16'(my);
      return r;
   endfunction

   stim_row_type directed[$];
   int      shape_roll;
   logic [KREG_BITS-1:0] window_plan[8] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd5, 4'd12, 4'd3};
   int      idle_plan[4][2] = '{'{0, 0}, '{75, 0}, '{0, 75}, '{24, 24}};

   function automatic void add_row(req_type pt, bit typed, rsp_type want);
      stim_row_type row;
      row.pt    = pt;
      row.typed = typed;
      row.want  = want;
      directed.insert(directed.size(), row);
   endfunction

   initial begin
      rsp_type none_want;
      none_want     = '0;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_payload   <= '0;
      rsp_stall     <= 1'b0;
      csr_valid     <= 1'b0;
      csr_data      <= '0;
      error_count   = 0;
      cycle_count   = 0;
      send_idle_pct = 0;
      stall_pct     = 0;
      items_sent    = 0;
      predictor_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Single points at the coordinate extremes are both first and last interest point.
      add_row(make_point(32767, -32768, 1'b1), 1'b1,
              two_point(CLASS_NONE, 32767, -32768, 32767, -32768, 0, 0));
      add_row(make_point(-32768, 32767, 1'b1), 1'b1,
              two_point(CLASS_NONE, -32768, 32767, -32768, 32767, 0, 0));
      add_row(make_point(0, 0, 1'b0), 1'b0, none_want);
      add_row(make_point(100, 0, 1'b1), 1'b1,
              two_point(CLASS_PEDESTRIAN, 0, 0, 100, 0, 50, 0));
      // Negative midpoint rounds down.
      add_row(make_point(-1, -1, 1'b0), 1'b0, none_want);
      add_row(make_point(-2, -1, 1'b1), 1'b1,
              two_point(CLASS_PEDESTRIAN, -1, -1, -2, -1, -2, -1));
      add_row(make_point(0, 0, 1'b0), 1'b0, none_want);
      add_row(make_point(300, 0, 1'b1), 1'b1,
              two_point(CLASS_FRONT, 0, 0, 300, 0, 0, 0));
      // Zero dx fails the slope test.
      add_row(make_point(0, 0, 1'b0), 1'b0, none_want);
      add_row(make_point(0, 100, 1'b1), 1'b1,
              two_point(CLASS_NONE, 0, 0, 0, 100, 0, 0));
      // Repeated points give zero-length vectors, so no middle point passes.
      for (int i = 0; i < 7; i++)
         add_row(make_point(500, 500, i == 6), i == 6,
                 two_point(CLASS_NONE, 500, 500, 500, 500, 0, 0));
      for (int i = 0; i < 5; i++)
         add_row(make_point(-512 + 128 * i, 0, 1'b0), 1'b0, none_want);
      for (int i = 1; i <= 3; i++)
         add_row(make_point(0, 100 * i, i == 3), 1'b0, none_want);
      foreach (directed[i]) send_point(directed[i].pt, directed[i].typed, directed[i].want);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         write_window(window_plan[ph]);
         send_idle_pct = idle_plan[ph % 4][0];
         stall_pct     = idle_plan[ph % 4][1];
         items_sent    = 0;
         while (items_sent < ITEMS_PER_PHASE) begin
            shape_roll = $urandom_range(99);
            build_cluster(shape_roll < 40 ? SHAPE_CORNER :
                          shape_roll < 60 ? SHAPE_FRONT :
                          shape_roll < 80 ? SHAPE_PEDESTRIAN : SHAPE_NOISE);
            foreach (shape_pts[i]) send_point(shape_pts[i], 1'b0, none_want);
         end
         drain();
      end

      if (class_queue.size() != 0) error_count++;
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+src
src/sccc_pkg.sv
src/sccc_mul.sv
src/sccc_angle.sv
src/scan_cluster_corner_classifier_unit.sv
tb/sv/testbench.sv
